>>> src/line_rasterizer_assert.svh
// Assertion macros for the line rasterizer checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lr_pkg.sv
// Shared types and constants for the line rasterizer.
// No dependencies; imported by every module of the block.
package lr_pkg;

    localparam int GRID_SIZE_DEF = 32;
    localparam int COORD_W       = 5;
    localparam int PIX_X_W       = 6;
    localparam int VALUE_W       = 32;

    typedef enum logic [1:0] {
        SRC_COL  = 2'd0,
        SRC_GAP  = 2'd1,
        SRC_VRUN = 2'd2
    } pix_src_t;

    typedef struct packed {
        logic     capture;
        logic     div_start;
        logic     emit;
        pix_src_t src;
        logic     last;
        logic     gap_init;
        logic     row_inc;
        logic     advance;
    } dp_cmd_t;

    typedef struct packed {
        logic vert;
        logic gap_need;
        logic gap_last;
        logic at_end;
        logic row_at_hi;
        logic div_busy;
        logic emit_ok;
    } dp_stat_t;

endpackage

>>> src/line_rasterizer.sv
// Line rasterizer: one line command in, its pixel writes out in order.
// Command channel: cmd_valid/cmd_ready carry start_x, start_y, end_x, end_y
// and paint_value. Pixel channel: pix_valid/pix_ready carry pixel_x,
// pixel_y, pixel_value and last_pixel, which marks the final word of a line.
// One command is worked at a time; cmd_ready is high only while idle, and
// drops for the whole line once a command is taken.
// A vertical line or single point goes from capture through the prep state
// straight to its vertical run; any other line first runs the bit-serial
// slope divide in the divide state, then goes on to its column words.
// After that, one pixel word goes out per cycle while pix_ready stays high.
// The last word sits in the output register while the next command is taken.
// A stall on pix_ready holds the output word and the emitting states.
// Reset clears the controller to idle and empties the output register.
// Depends on lr_pkg, lr_ctrl, lr_dp.
module line_rasterizer #(
    parameter int GRID_SIZE = lr_pkg::GRID_SIZE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  logic [lr_pkg::COORD_W-1:0] start_x,
    input  logic [lr_pkg::COORD_W-1:0] start_y,
    input  logic [lr_pkg::COORD_W-1:0] end_x,
    input  logic [lr_pkg::COORD_W-1:0] end_y,
    input  logic [lr_pkg::VALUE_W-1:0] paint_value,
    output logic                       pix_valid,
    input  logic                       pix_ready,
    output logic [lr_pkg::PIX_X_W-1:0] pixel_x,
    output logic [lr_pkg::COORD_W-1:0] pixel_y,
    output logic [lr_pkg::VALUE_W-1:0] pixel_value,
    output logic                       last_pixel
);
    import lr_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    lr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    lr_dp #(
        .GRID_SIZE (GRID_SIZE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dp_cmd),
        .stat        (dp_stat),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .paint_value (paint_value),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_value (pixel_value),
        .last_pixel  (last_pixel)
    );

endmodule

>>> src/lr_div.sv
// Restoring divider for the slope: one quotient bit per cycle.
// Depends on lr_pkg.
module lr_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lr_pkg::COORD_W-1:0] dividend,
    input  logic [lr_pkg::COORD_W-1:0] divisor,
    output logic                       busy,
    output logic [lr_pkg::COORD_W-1:0] quot,
    output logic [lr_pkg::COORD_W-1:0] rem
);
    import lr_pkg::*;

    localparam int CNT_W = $clog2(COORD_W + 1);

    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [COORD_W-1:0] quo_reg, quo_next;
    logic [COORD_W-1:0] rem_reg, rem_next;
    logic [COORD_W:0]   trial;
    logic [COORD_W:0]   trial_sub;
    logic               fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[COORD_W-1]};
        trial_sub = trial - {1'b0, divisor};
        fits      = trial >= {1'b0, divisor};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(COORD_W);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[COORD_W-2:0], fits};
            rem_next = fits ? trial_sub[COORD_W-1:0] : trial[COORD_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

>>> src/lr_dp.sv
// Datapath: endpoint capture, column stepping, gap rows and the output register.
// Depends on lr_pkg and lr_div.
module lr_dp #(
    parameter int GRID_SIZE = lr_pkg::GRID_SIZE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lr_pkg::dp_cmd_t            cmd,
    output lr_pkg::dp_stat_t           stat,
    input  logic [lr_pkg::COORD_W-1:0] start_x,
    input  logic [lr_pkg::COORD_W-1:0] start_y,
    input  logic [lr_pkg::COORD_W-1:0] end_x,
    input  logic [lr_pkg::COORD_W-1:0] end_y,
    input  logic [lr_pkg::VALUE_W-1:0] paint_value,
    output logic                       pix_valid,
    input  logic                       pix_ready,
    output logic [lr_pkg::PIX_X_W-1:0] pixel_x,
    output logic [lr_pkg::COORD_W-1:0] pixel_y,
    output logic [lr_pkg::VALUE_W-1:0] pixel_value,
    output logic                       last_pixel
);
    import lr_pkg::*;

    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIZE - 1);

    logic [COORD_W-1:0] cx1, cy1, cx2, cy2;
    logic [COORD_W-1:0] lx, ly, rx, ry;
    logic               swap, in_rise;

    logic [PIX_X_W-1:0] x_reg;
    logic [COORD_W-1:0] x_end_reg;
    logic [COORD_W-1:0] y_reg, prev_reg, row_reg, y_end_reg;
    logic [COORD_W-1:0] dx_reg, dy_reg, r_reg;
    logic               rise_reg, vert_reg;
    logic [VALUE_W-1:0] value_reg;

    logic [COORD_W-1:0] quot, rem;
    logic               div_busy;

    logic [COORD_W:0]   sum, r_diff, step, y_wide;
    logic               carry;
    logic [COORD_W-1:0] r_new, y_next;

    logic [PIX_X_W-1:0] sel_x;
    logic [COORD_W-1:0] sel_y;
    logic               gap_last;

    logic               pix_valid_reg;
    logic [PIX_X_W-1:0] pix_x_reg;
    logic [COORD_W-1:0] pix_y_reg;
    logic [VALUE_W-1:0] pix_value_reg;
    logic               last_reg;

    function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] c);
        return (c > COORD_MAX) ? COORD_MAX : c;
    endfunction

    lr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dy_reg),
        .divisor  (dx_reg),
        .busy     (div_busy),
        .quot     (quot),
        .rem      (rem)
    );

    always_comb
    begin
        cx1     = clamp(start_x);
        cy1     = clamp(start_y);
        cx2     = clamp(end_x);
        cy2     = clamp(end_y);
        swap    = cx1 > cx2;
        lx      = swap ? cx2 : cx1;
        ly      = swap ? cy2 : cy1;
        rx      = swap ? cx1 : cx2;
        ry      = swap ? cy1 : cy2;
        in_rise = ry > ly;
    end

    always_comb
    begin
        sum    = {1'b0, r_reg} + {1'b0, rem};
        carry  = sum >= {1'b0, dx_reg};
        r_diff = sum - {1'b0, dx_reg};
        r_new  = carry ? r_diff[COORD_W-1:0] : sum[COORD_W-1:0];
        step   = {1'b0, quot} + {{COORD_W{1'b0}}, carry};
        y_wide = rise_reg ? ({1'b0, y_reg} + step) : ({1'b0, y_reg} - step);
        y_next = y_wide[COORD_W-1:0];
    end

    always_comb
    begin
        gap_last = rise_reg ? (row_reg == y_reg) : (row_reg == prev_reg - COORD_W'(1));
        case (cmd.src)
            SRC_COL:
            begin
                sel_x = x_reg;
                sel_y = y_reg;
            end
            SRC_GAP:
            begin
                if (!gap_last)
                begin
                    sel_x = x_reg;
                end
                else if (rise_reg)
                begin
                    sel_x = x_reg + PIX_X_W'(1);
                end
                else
                begin
                    sel_x = x_reg - PIX_X_W'(1);
                end
                sel_y = row_reg;
            end
            SRC_VRUN:
            begin
                sel_x = x_reg;
                sel_y = row_reg;
            end
            default:
            begin
                sel_x = x_reg;
                sel_y = y_reg;
            end
        endcase
    end

    always_comb
    begin
        stat.vert      = vert_reg;
        stat.gap_need  = rise_reg ? ({1'b0, y_reg} > ({1'b0, prev_reg} + 6'd1))
                                  : (({1'b0, y_reg} + 6'd1) < {1'b0, prev_reg});
        stat.gap_last  = gap_last;
        stat.at_end    = x_reg == {1'b0, x_end_reg};
        stat.row_at_hi = row_reg == y_end_reg;
        stat.div_busy  = div_busy;
        stat.emit_ok   = !pix_valid_reg || pix_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg     <= {1'b0, lx};
            x_end_reg <= rx;
            y_reg     <= ly;
            prev_reg  <= ly;
            r_reg     <= '0;
            dx_reg    <= rx - lx;
            dy_reg    <= in_rise ? (ry - ly) : (ly - ry);
            rise_reg  <= in_rise;
            vert_reg  <= cx1 == cx2;
            row_reg   <= (cy1 < cy2) ? cy1 : cy2;
            y_end_reg <= (cy1 < cy2) ? cy2 : cy1;
            value_reg <= paint_value;
        end
        else
        begin
            if (cmd.gap_init)
            begin
                row_reg <= rise_reg ? (prev_reg + COORD_W'(1)) : y_reg;
            end
            else if (cmd.row_inc)
            begin
                row_reg <= row_reg + COORD_W'(1);
            end
            if (cmd.advance)
            begin
                x_reg    <= x_reg + PIX_X_W'(1);
                prev_reg <= y_reg;
                y_reg    <= y_next;
                r_reg    <= r_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            pix_valid_reg <= 1'b1;
        end
        else if (pix_ready)
        begin
            pix_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pix_x_reg     <= sel_x;
            pix_y_reg     <= sel_y;
            pix_value_reg <= value_reg;
            last_reg      <= cmd.last;
        end
    end

    assign pix_valid   = pix_valid_reg;
    assign pixel_x     = pix_x_reg;
    assign pixel_y     = pix_y_reg;
    assign pixel_value = pix_value_reg;
    assign last_pixel  = last_reg;

endmodule

>>> src/lr_ctrl.sv
// Controller: sequences capture, slope divide, column, gap and vertical-run words.
// Depends on lr_pkg.
module lr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  lr_pkg::dp_stat_t stat,
    output lr_pkg::dp_cmd_t  cmd
);
    import lr_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PREP = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_COL  = 6'b001000,
        ST_GAP  = 6'b010000,
        ST_VRUN = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.src    = SRC_COL;
        cmd_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (stat.vert)
                begin
                    state_next = ST_VRUN;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_COL;
                end
            end
            ST_COL:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit = 1'b1;
                    cmd.src  = SRC_COL;
                    cmd.last = stat.at_end && !stat.gap_need;
                    if (stat.gap_need)
                    begin
                        cmd.gap_init = 1'b1;
                        state_next   = ST_GAP;
                    end
                    else if (stat.at_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            ST_GAP:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit = 1'b1;
                    cmd.src  = SRC_GAP;
                    cmd.last = stat.at_end && stat.gap_last;
                    if (!stat.gap_last)
                    begin
                        cmd.row_inc = 1'b1;
                    end
                    else if (stat.at_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_COL;
                    end
                end
            end
            ST_VRUN:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit = 1'b1;
                    cmd.src  = SRC_VRUN;
                    cmd.last = stat.row_at_hi;
                    if (stat.row_at_hi)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.row_inc = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/lr_chk.sv
// Port-level checker for the line rasterizer, bound to the top level.
// Depends on lr_pkg and line_rasterizer_assert.svh.
`include "line_rasterizer_assert.svh"

module lr_chk #(
    parameter int GRID_SIZE = lr_pkg::GRID_SIZE_DEF
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cmd_valid,
    input logic                       cmd_ready,
    input logic                       pix_valid,
    input logic                       pix_ready,
    input logic [lr_pkg::PIX_X_W-1:0] pixel_x,
    input logic [lr_pkg::COORD_W-1:0] pixel_y,
    input logic [lr_pkg::VALUE_W-1:0] pixel_value,
    input logic                       last_pixel
);
    import lr_pkg::*;

    `LR_ASSERT_NEXT(a_pix_hold, pix_valid && !pix_ready,
        pix_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_value),
        "pixel word changed while stalled")

    `LR_ASSERT_SAME(a_x_range, pix_valid, pixel_x <= PIX_X_W'(GRID_SIZE),
        "pixel column beyond grid edge")

    `LR_ASSERT_SAME(a_busy_mid_line, pix_valid && !last_pixel, !cmd_ready,
        "command taken before line finished")

    `LR_ASSERT_NEXT(a_one_cmd, cmd_valid && cmd_ready, !cmd_ready,
        "second command taken while line in progress")

endmodule

bind line_rasterizer lr_chk #(.GRID_SIZE(GRID_SIZE)) u_lr_chk (.*);

>>> dv/tb_line_rasterizer.sv
// Testbench for line_rasterizer: sends line commands with random idle gaps and
// random pixel stalls, predicts every pixel word and checks them in order.
// Depends on lr_pkg and the line_rasterizer RTL.
module tb_line_rasterizer;
    import lr_pkg::*;

    localparam int MAX_WORDS    = 63;
    localparam int NUM_RANDOM   = 250;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        logic [PIX_X_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [VALUE_W-1:0] value;
        logic               last;
    } pixel_t;

    class pixel_scoreboard;
        pixel_t             pending_pixels[$];
        pixel_t             line_words[$];
        logic [VALUE_W-1:0] paint;
        int                 errors;

        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        function void plot(int col, int row);
            pixel_t p;
            if (line_words.size() < MAX_WORDS)
            begin
                p.col   = PIX_X_W'(col);
                p.row   = COORD_W'(row);
                p.value = paint;
                p.last  = 1'b0;
                line_words.push_back(p);
            end
        endfunction

        function void note_line(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                                logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey,
                                logic [VALUE_W-1:0] v);
            int x1, y1, x2, y2, t, dx, dy, prev, y, gap, i, g;
            x1 = sx;
            y1 = sy;
            x2 = ex;
            y2 = ey;
            paint = v;
            line_words.delete();
            if (x1 == x2 && y1 == y2)
            begin
                plot(x1, y1);
            end
            else if (x1 == x2)
            begin
                if (y1 > y2)
                begin
                    t = y1; y1 = y2; y2 = t;
                end
                for (t = y1; t <= y2; t++)
                    plot(x1, t);
            end
            else if (y1 == y2)
            begin
                if (x1 > x2)
                begin
                    t = x1; x1 = x2; x2 = t;
                end
                for (t = x1; t <= x2; t++)
                    plot(t, y1);
            end
            else
            begin
                if (x1 > x2)
                begin
                    t = x1; x1 = x2; x2 = t;
                    t = y1; y1 = y2; y2 = t;
                end
                dx = x2 - x1;
                prev = y1;
                if (y2 > y1)
                begin
                    dy = y2 - y1;
                    for (i = 0; i <= dx; i++)
                    begin
                        y = y1 + (i * dy) / dx;
                        plot(x1 + i, y);
                        if (y > prev + 1)
                        begin
                            gap = y - (prev + 1);
                            for (g = 0; g <= gap; g++)
                                plot(x1 + i + ((g == gap) ? 1 : 0), prev + 1 + g);
                        end
                        prev = y;
                    end
                end
                else
                begin
                    dy = y1 - y2;
                    for (i = 0; i <= dx; i++)
                    begin
                        y = y1 - (i * dy) / dx;
                        plot(x1 + i, y);
                        if (y + 1 < prev)
                        begin
                            gap = (prev - 1) - y;
                            for (g = 0; g <= gap; g++)
                                plot(x1 + i - ((g == gap) ? 1 : 0), y + g);
                        end
                        prev = y;
                    end
                end
            end
            line_words[line_words.size() - 1].last = 1'b1;
            foreach (line_words[k])
                pending_pixels.push_back(line_words[k]);
        endfunction

        task check_pixel(logic [PIX_X_W-1:0] col, logic [COORD_W-1:0] row,
                         logic [VALUE_W-1:0] value, logic last);
            pixel_t e;
            if (pending_pixels.size() == 0)
            begin
                report($sformatf("unexpected word x=%0d y=%0d value=%h last=%b",
                                 col, row, value, last));
            end
            else
            begin
                e = pending_pixels.pop_front();
                if (col !== e.col)
                    report($sformatf("pixel_x %0d, expected %0d", col, e.col));
                if (row !== e.row)
                    report($sformatf("pixel_y %0d, expected %0d", row, e.row));
                if (value !== e.value)
                    report($sformatf("pixel_value %h, expected %h", value, e.value));
                if (last !== e.last)
                    report($sformatf("last_pixel %b, expected %b", last, e.last));
            end
        endtask
    endclass

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cmd_valid   = 1'b0;
    logic               cmd_ready;
    logic [COORD_W-1:0] start_x     = '0;
    logic [COORD_W-1:0] start_y     = '0;
    logic [COORD_W-1:0] end_x       = '0;
    logic [COORD_W-1:0] end_y       = '0;
    logic [VALUE_W-1:0] paint_value = '0;
    logic               pix_valid;
    logic               pix_ready   = 1'b0;
    logic [PIX_X_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [VALUE_W-1:0] pixel_value;
    logic               last_pixel;

    bit              no_idle    = 1'b0;
    int              stall_left = 0;
    pixel_scoreboard sb         = new();

    line_rasterizer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .paint_value (paint_value),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_value (pixel_value),
        .last_pixel  (last_pixel)
    );

    always #5 clk = ~clk;

    function automatic int idle_gap();
        int r;
        if (no_idle || $urandom_range(0, 1) == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 90)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    task automatic send_line(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                             input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                             input logic [VALUE_W-1:0] v);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid   <= 1'b1;
        start_x     <= sx;
        start_y     <= sy;
        end_x       <= ex;
        end_y       <= ey;
        paint_value <= v;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        sb.note_line(sx, sy, ex, ey, v);
    endtask

    task automatic send_random_line();
        logic [COORD_W-1:0] sx, sy, ex, ey;
        int kind, d;
        sx = COORD_W'($urandom);
        sy = COORD_W'($urandom);
        ex = COORD_W'($urandom);
        ey = COORD_W'($urandom);
        kind = $urandom_range(0, 99);
        d = $urandom_range(1, 3);
        if (kind < 5)
        begin
            ex = sx;
            ey = sy;
        end
        else if (kind < 15)
            ex = sx;
        else if (kind < 25)
            ey = sy;
        else if (kind < 45)
            ex = $urandom_range(0, 1) ? COORD_W'(sx + d) : COORD_W'(sx - d);
        else if (kind < 55)
            ey = $urandom_range(0, 1) ? COORD_W'(sy + d) : COORD_W'(sy - d);
        send_line(sx, sy, ex, ey, VALUE_W'($urandom));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_valid && pix_ready)
                sb.check_pixel(pixel_x, pixel_y, pixel_value, last_pixel);
            if (stall_left > 0)
            begin
                pix_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                pix_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = idle_gap();
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_line(5'd0,  5'd0,  5'd0,  5'd0,  32'h0000_0000);
        send_line(5'd31, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF);
        send_line(5'd5,  5'd0,  5'd5,  5'd31, 32'hA5A5_A5A5);
        send_line(5'd7,  5'd31, 5'd7,  5'd0,  32'h5A5A_5A5A);
        send_line(5'd0,  5'd3,  5'd31, 5'd3,  32'h0000_0001);
        send_line(5'd31, 5'd9,  5'd0,  5'd9,  32'h8000_0000);
        send_line(5'd0,  5'd0,  5'd31, 5'd31, 32'hFFFF_FFFF);
        send_line(5'd31, 5'd0,  5'd0,  5'd31, 32'h0000_0000);
        send_line(5'd0,  5'd0,  5'd1,  5'd31, 32'h1234_5678);
        send_line(5'd30, 5'd0,  5'd31, 5'd31, 32'h8765_4321);
        send_line(5'd31, 5'd0,  5'd30, 5'd31, 32'hDEAD_BEEF);
        send_line(5'd1,  5'd31, 5'd0,  5'd0,  32'hCAFE_F00D);
        send_line(5'd0,  5'd31, 5'd1,  5'd0,  32'h0F0F_0F0F);
        send_line(5'd0,  5'd0,  5'd31, 5'd1,  32'hF0F0_F0F0);
        send_line(5'd0,  5'd10, 5'd31, 5'd0,  32'h3333_3333);
        send_line(5'd3,  5'd4,  5'd10, 5'd25, 32'hCCCC_CCCC);
        send_line(5'd20, 5'd2,  5'd4,  5'd17, 32'h5555_5555);
        send_line(5'd31, 5'd31, 5'd0,  5'd0,  32'hAAAA_AAAA);
        send_line(5'd2,  5'd5,  5'd4,  5'd30, 32'h7FFF_FFFF);
        send_line(5'd0,  5'd31, 5'd31, 5'd30, 32'hFFFF_FFFE);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_random_line();
        end
        cmd_valid <= 1'b0;

        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("** line_rasterizer: PASSED **");
        else
            $display("** line_rasterizer: FAILED **");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("TIMEOUT: %0d words still expected", sb.pending_pixels.size());
        $display("** line_rasterizer: FAILED **");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/lr_pkg.sv
src/lr_div.sv
src/lr_dp.sv
src/lr_ctrl.sv
src/line_rasterizer.sv
src/lr_chk.sv
dv/tb_line_rasterizer.sv
